// File: design/atd_pkg.sv
package atd_pkg;

	// fixed field widths
	localparam int AXIS_W     = 16;
	localparam int TIME_W     = 32;
	localparam int IMPACT_W   = 16;
	localparam int ROOT_W     = 16;
	localparam int SUM_W      = 32;
	localparam int BASE_W     = 24;
	localparam int THR_W      = 10;
	localparam int COOL_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// parameter defaults
	localparam int COUNTS_PER_G_DEF = 4096;
	localparam int FRAC_DEF         = 8;

	// sequencer lengths
	localparam int SQ_STEPS   = 4;
	localparam int ROOT_STEPS = 16;
	localparam int CNT_W      = $clog2(ROOT_STEPS);

	// arithmetic constants
	localparam logic [BASE_W-1:0]   BASE_MAX    = '1;
	localparam logic [IMPACT_W-1:0] IMPACT_MAX  = '1;
	localparam logic [SUM_W-1:0]    ROOT_BIT0   = SUM_W'(1) << (SUM_W - 2);
	localparam logic [31:0]         RECIP5      = 32'hCCCC_CCCD;
	localparam int                  RECIP_SHIFT = 34;
	localparam int                  EMA_BIAS    = 10;

	// register reset values
	localparam logic              ENABLE_RST    = 1'b1;
	localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(50);
	localparam logic [COOL_W-1:0] COOLDOWN_RST  = COOL_W'(500);
	localparam logic              ACTION_RST    = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE,
		REG_THRESHOLD,
		REG_COOLDOWN,
		REG_ACTION
	} reg_idx_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		logic              enable;
		logic [THR_W-1:0]  threshold;
		logic [COOL_W-1:0] cooldown;
		logic              action_next;
	} cfg_t;

	typedef struct packed {
		logic  load;
		logic  acc_clr;
		logic  square;
		axis_t sq_idx;
		logic  accum;
		logic  root_step;
		logic  ema_mul;
		logic  ema_div;
		logic  impact;
		logic  scale;
		logic  finish;
	} cmd_t;

	typedef struct packed {
		logic skip;
	} status_t;

endpackage

// File: design/atd_ifs.sv
// sample channel
interface atd_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [atd_pkg::AXIS_W-1:0]   accel_x;
	logic signed [atd_pkg::AXIS_W-1:0]   accel_y;
	logic signed [atd_pkg::AXIS_W-1:0]   accel_z;
	logic        [atd_pkg::TIME_W-1:0]   time_ms;
	logic                                tilt_busy;

	modport source (output valid, accel_x, accel_y, accel_z, time_ms, tilt_busy, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, tilt_busy, output ready);
endinterface

// result channel
interface atd_result_if;
	logic                            valid;
	logic                            ready;
	logic                            tap_detected;
	logic                            page_next;
	logic [atd_pkg::IMPACT_W-1:0]    impact;
	logic                            armed;

	modport source (output valid, tap_detected, page_next, impact, armed, input ready);
	modport sink   (input valid, tap_detected, page_next, impact, armed, output ready);
endinterface

// register write channel
interface atd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [atd_pkg::CFG_IDX_W-1:0]     index;
	logic [atd_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: design/accel_tap_detector.sv
// Channel   Dir  Beat contents
// sample    in   accel_x, accel_y, accel_z, time_ms, tilt_busy
// result    out  tap_detected, page_next, impact, armed
// cfg       in   index, data (register write)
//
// One sample is worked at a time: accept, squaring, square-root steps,
// EMA/impact, then commit; when detection is disabled or tilt is busy the
// sample goes from accept straight to commit. The shared square-root unit
// works in 16 steps. Reset clears the baseline, tap time and armed flag.
// The result sits in an output register; while it waits the sample side takes
// one more sample, which runs up to the commit step and holds there, with the
// sample side not ready, until the waiting result is taken.
module accel_tap_detector #(
	parameter int COUNTS_PER_G       = atd_pkg::COUNTS_PER_G_DEF,
	parameter int BASELINE_FRAC_BITS = atd_pkg::FRAC_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	atd_sample_if.sink     sample,
	atd_result_if.source   result,
	atd_cfg_if.sink        cfg
);

	atd_pkg::cfg_t    regs;
	atd_pkg::cmd_t    cmd;
	atd_pkg::status_t status;

	atd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	atd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	atd_dp #(
		.COUNTS_PER_G       (COUNTS_PER_G),
		.BASELINE_FRAC_BITS (BASELINE_FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accel_x      (sample.accel_x),
		.accel_y      (sample.accel_y),
		.accel_z      (sample.accel_z),
		.time_ms      (sample.time_ms),
		.tilt_busy    (sample.tilt_busy),
		.regs         (regs),
		.cmd          (cmd),
		.status       (status),
		.tap_detected (result.tap_detected),
		.page_next    (result.page_next),
		.impact       (result.impact),
		.armed        (result.armed)
	);

endmodule

// File: design/atd_cfg.sv
module atd_cfg (
	input  logic            clk,
	input  logic            arst_n,
	atd_cfg_if.sink         cfg,
	output atd_pkg::cfg_t   regs
);

	atd_pkg::cfg_t regs_q;

	// always ready, writes are registered
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.enable      <= atd_pkg::ENABLE_RST;
			regs_q.threshold   <= atd_pkg::THRESHOLD_RST;
			regs_q.cooldown    <= atd_pkg::COOLDOWN_RST;
			regs_q.action_next <= atd_pkg::ACTION_RST;
		end else if (cfg.valid) begin
			unique case (atd_pkg::reg_idx_t'(cfg.index))
				atd_pkg::REG_ENABLE:    regs_q.enable      <= cfg.data[0];
				atd_pkg::REG_THRESHOLD: regs_q.threshold   <= cfg.data[atd_pkg::THR_W-1:0];
				atd_pkg::REG_COOLDOWN:  regs_q.cooldown    <= cfg.data[atd_pkg::COOL_W-1:0];
				atd_pkg::REG_ACTION:    regs_q.action_next <= cfg.data[0];
			endcase
		end
	end

endmodule

// File: design/atd_ctrl.sv
module atd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  atd_pkg::status_t   status,
	output atd_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQ,
		S_ROOT,
		S_MUL,
		S_DIV,
		S_IMP,
		S_SCALE,
		S_FINISH
	} state_t;

	state_t                       state_q;
	logic [atd_pkg::CNT_W-1:0]    cnt_q;
	logic                         out_valid_q;
	logic                         fin_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// result register free, or being emptied this cycle
	assign fin_ok    = !out_valid_q || out_ready;

	// command decode
	always_comb begin
		cmd        = '0;
		cmd.sq_idx = atd_pkg::AXIS_X;
		unique case (state_q)
			S_IDLE:   cmd.load = in_valid;
			S_SQ: begin
				unique case (cnt_q[1:0])
					2'd0: begin
						cmd.acc_clr = 1'b1;
						cmd.square  = 1'b1;
						cmd.sq_idx  = atd_pkg::AXIS_X;
					end
					2'd1: begin
						cmd.accum  = 1'b1;
						cmd.square = 1'b1;
						cmd.sq_idx = atd_pkg::AXIS_Y;
					end
					2'd2: begin
						cmd.accum  = 1'b1;
						cmd.square = 1'b1;
						cmd.sq_idx = atd_pkg::AXIS_Z;
					end
					2'd3:     cmd.accum = 1'b1;
				endcase
			end
			S_ROOT:   cmd.root_step = 1'b1;
			S_MUL:    cmd.ema_mul   = 1'b1;
			S_DIV:    cmd.ema_div   = 1'b1;
			S_IMP:    cmd.impact    = 1'b1;
			S_SCALE:  cmd.scale     = 1'b1;
			S_FINISH: cmd.finish    = fin_ok;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result flag: set on commit, cleared when the beat is taken
			if (state_q == S_FINISH && fin_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= status.skip ? S_FINISH : S_SQ;
					end
				end
				S_SQ: begin
					if (cnt_q == atd_pkg::CNT_W'(atd_pkg::SQ_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROOT: begin
					if (cnt_q == atd_pkg::CNT_W'(atd_pkg::ROOT_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MUL:   state_q <= S_DIV;
				S_DIV:   state_q <= S_IMP;
				S_IMP:   state_q <= S_SCALE;
				S_SCALE: state_q <= S_FINISH;
				S_FINISH: begin
					if (fin_ok) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// File: design/atd_dp.sv
module atd_dp #(
	parameter int COUNTS_PER_G       = atd_pkg::COUNTS_PER_G_DEF,
	parameter int BASELINE_FRAC_BITS = atd_pkg::FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [atd_pkg::AXIS_W-1:0]   accel_x,
	input  logic signed [atd_pkg::AXIS_W-1:0]   accel_y,
	input  logic signed [atd_pkg::AXIS_W-1:0]   accel_z,
	input  logic        [atd_pkg::TIME_W-1:0]   time_ms,
	input  logic                                tilt_busy,
	input  atd_pkg::cfg_t                       regs,
	input  atd_pkg::cmd_t                       cmd,
	output atd_pkg::status_t                    status,
	output logic                                tap_detected,
	output logic                                page_next,
	output logic        [atd_pkg::IMPACT_W-1:0] impact,
	output logic                                armed
);

	localparam int FRAC   = BASELINE_FRAC_BITS;
	localparam int MAG_W  = atd_pkg::ROOT_W + FRAC;
	localparam int IMP_W  = (MAG_W > atd_pkg::BASE_W) ? MAG_W : atd_pkg::BASE_W;
	localparam int V_W    = ((MAG_W > atd_pkg::BASE_W + 5) ? MAG_W : atd_pkg::BASE_W + 5) + 1;
	localparam int Q_W    = 64 - atd_pkg::RECIP_SHIFT;
	localparam int SEL_W  = (MAG_W > Q_W) ? MAG_W : Q_W;
	localparam int ONEG_W = $clog2(COUNTS_PER_G + 1) + FRAC;
	localparam int CMP_W  = (IMP_W + 7 > ONEG_W + atd_pkg::THR_W)
	                        ? IMP_W + 7 : ONEG_W + atd_pkg::THR_W;
	localparam logic [CMP_W-1:0] ONE_G    = CMP_W'(COUNTS_PER_G) << FRAC;
	localparam logic [CMP_W-1:0] REARM_FX = ONE_G << 3;

	// persistent detector state
	logic [atd_pkg::BASE_W-1:0]  base_q;
	logic [atd_pkg::TIME_W-1:0]  last_q;
	logic                        armed_q;

	// working registers
	logic [atd_pkg::AXIS_W-1:0]  ax_q, ay_q, az_q;
	logic [atd_pkg::TIME_W-1:0]  time_q;
	logic                        en_q, busy_q;
	logic [atd_pkg::SUM_W-1:0]   sq_q, acc_q, res_q, bit_q;
	logic [63:0]                 prod_q;
	logic                        seed_q;
	logic [atd_pkg::BASE_W-1:0]  nb_q;
	logic [CMP_W-1:0]            thr_fx_q;
	logic [IMP_W-1:0]            impact_q;
	logic [CMP_W-1:0]            imp100_q;
	logic                        cool_q;

	// result register
	logic                        tap_q, page_q, arm_out_q;
	logic [atd_pkg::IMPACT_W-1:0] imp_out_q;

	logic [atd_pkg::AXIS_W-1:0]  sq_op;
	logic [atd_pkg::SUM_W:0]     trial;
	logic [MAG_W-1:0]            mag_fx;
	logic [V_W-1:0]              ema_sum;
	logic [SEL_W-1:0]            cand;
	logic [IMP_W-1:0]            mag_ext, nb_ext, imp_shift;
	logic [atd_pkg::IMPACT_W-1:0] imp_sat;
	logic                        tap_now;

	assign status.skip = !regs.enable || tilt_busy;

	// squarer operand select
	always_comb begin
		case (cmd.sq_idx)
			atd_pkg::AXIS_X: sq_op = ax_q;
			atd_pkg::AXIS_Y: sq_op = ay_q;
			atd_pkg::AXIS_Z: sq_op = az_q;
			default:         sq_op = '0;
		endcase
	end

	assign trial   = {1'b0, res_q} + {1'b0, bit_q};
	assign mag_fx  = MAG_W'(res_q[atd_pkg::ROOT_W-1:0]) << FRAC;
	// 19*base + mag + bias
	assign ema_sum = (V_W'(base_q) << 4) + (V_W'(base_q) << 1) + V_W'(base_q)
	               + V_W'(mag_fx) + V_W'(atd_pkg::EMA_BIAS);
	assign cand    = seed_q ? SEL_W'(mag_fx) : SEL_W'(prod_q[63:atd_pkg::RECIP_SHIFT]);
	assign mag_ext = IMP_W'(mag_fx);
	assign nb_ext  = IMP_W'(nb_q);

	assign imp_shift = impact_q >> FRAC;
	assign imp_sat   = (imp_shift > IMP_W'(atd_pkg::IMPACT_MAX))
	                   ? atd_pkg::IMPACT_MAX : imp_shift[atd_pkg::IMPACT_W-1:0];
	assign tap_now   = !cool_q && armed_q && (imp100_q > thr_fx_q);

	// magnitude, EMA and impact datapath
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q   <= accel_x[atd_pkg::AXIS_W-1] ? atd_pkg::AXIS_W'(-accel_x) : accel_x;
			ay_q   <= accel_y[atd_pkg::AXIS_W-1] ? atd_pkg::AXIS_W'(-accel_y) : accel_y;
			az_q   <= accel_z[atd_pkg::AXIS_W-1] ? atd_pkg::AXIS_W'(-accel_z) : accel_z;
			time_q <= time_ms;
			en_q   <= regs.enable;
			busy_q <= tilt_busy;
		end
		if (cmd.square) begin
			sq_q <= atd_pkg::SUM_W'(sq_op) * atd_pkg::SUM_W'(sq_op);
		end
		// sum of squares, then the same register serves as the root remainder
		if (cmd.acc_clr) begin
			acc_q <= '0;
			res_q <= '0;
			bit_q <= atd_pkg::ROOT_BIT0;
		end else if (cmd.accum) begin
			acc_q <= acc_q + sq_q;
		end else if (cmd.root_step) begin
			if ({1'b0, acc_q} >= trial) begin
				acc_q <= acc_q - trial[atd_pkg::SUM_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		// divide by 20: drop two bits, then reciprocal of five
		if (cmd.ema_mul) begin
			prod_q <= {32'b0, 32'(ema_sum >> 2)} * {32'b0, atd_pkg::RECIP5};
			seed_q <= ((CMP_W'(base_q) << 3) + (CMP_W'(base_q) << 1)) < ONE_G;
		end
		if (cmd.ema_div) begin
			nb_q     <= (cand > SEL_W'(atd_pkg::BASE_MAX)) ? atd_pkg::BASE_MAX
			            : cand[atd_pkg::BASE_W-1:0];
			thr_fx_q <= CMP_W'(regs.threshold) * ONE_G;
		end
		if (cmd.impact) begin
			impact_q <= (mag_ext >= nb_ext) ? mag_ext - nb_ext : nb_ext - mag_ext;
		end
		if (cmd.scale) begin
			imp100_q <= (CMP_W'(impact_q) << 6) + (CMP_W'(impact_q) << 5)
			          + (CMP_W'(impact_q) << 2);
			cool_q   <= (time_q - last_q) < atd_pkg::TIME_W'(regs.cooldown);
		end
		// result register
		if (cmd.finish) begin
			if (!en_q) begin
				tap_q     <= 1'b0;
				page_q    <= 1'b0;
				imp_out_q <= '0;
				arm_out_q <= armed_q;
			end else if (busy_q) begin
				tap_q     <= 1'b0;
				page_q    <= 1'b0;
				imp_out_q <= '0;
				arm_out_q <= 1'b0;
			end else begin
				tap_q     <= tap_now;
				page_q    <= tap_now && regs.action_next;
				imp_out_q <= imp_sat;
				if (cool_q || tap_now) begin
					arm_out_q <= 1'b0;
				end else if (!armed_q) begin
					arm_out_q <= imp100_q < REARM_FX;
				end else begin
					arm_out_q <= armed_q;
				end
			end
		end
	end

	// detector state, committed with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			last_q  <= '0;
			armed_q <= 1'b0;
		end else if (cmd.finish && en_q) begin
			if (busy_q) begin
				armed_q <= 1'b0;
			end else begin
				base_q <= nb_q;
				if (cool_q) begin
					armed_q <= 1'b0;
				end else if (!armed_q) begin
					armed_q <= imp100_q < REARM_FX;
				end else if (tap_now) begin
					armed_q <= 1'b0;
					last_q  <= time_q;
				end
			end
		end
	end

	assign tap_detected = tap_q;
	assign page_next    = page_q;
	assign impact       = imp_out_q;
	assign armed        = arm_out_q;

endmodule

// File: design/atd_checker.sv
module atd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic tap_detected,
	input logic page_next,
	input logic armed
);

	// a result beat stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before taken");

	// one sample in flight: no accept straight after an accept
	a_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second sample taken while one is in flight");

	// a tap always leaves the detector disarmed
	a_tap_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tap_detected |-> !armed)
		else $error("tap reported with detector still armed");

	// page action only comes with a tap
	a_page_tap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && page_next |-> tap_detected)
		else $error("page action without a tap");

endmodule

bind accel_tap_detector atd_checker u_atd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample.valid),
	.in_ready     (sample.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.tap_detected (result.tap_detected),
	.page_next    (result.page_next),
	.armed        (result.armed)
);

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
	import atd_pkg::*;

	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     HOLD_CYCLES    = 400;
	localparam int     TAIL_CYCLES    = 40;
	localparam int     REPORT_LIMIT   = 10;
	localparam longint ONE_G_FX       = longint'(COUNTS_PER_G_DEF) << FRAC_DEF;
	localparam longint BASE_CEIL      = (longint'(1) << BASE_W) - 1;
	localparam longint IMPACT_CEIL    = (longint'(1) << IMPACT_W) - 1;
	// EMA: 19/20 of the old baseline, 1/20 of the new magnitude, rounded
	localparam longint EMA_KEEP       = 19;
	localparam longint EMA_DIV        = 20;
	localparam longint SEED_TENTHS    = 10;
	localparam longint REARM_CENTI_G  = 8;
	localparam int     G_COUNTS       = COUNTS_PER_G_DEF;

	// phases of the random part
	localparam int N_PHASES       = 9;
	localparam int PRESSURE_PHASE = 3;
	localparam int STEADY_PHASE   = 5;
	localparam int RANDOM_PHASE   = 6;
	localparam int WRAP_PHASE     = 7;

	typedef struct packed {
		logic signed [AXIS_W-1:0] ax;
		logic signed [AXIS_W-1:0] ay;
		logic signed [AXIS_W-1:0] az;
		logic [TIME_W-1:0]        tms;
		logic                     busy;
	} accel_sample_t;

	typedef struct packed {
		logic                tap;
		logic                page;
		logic [IMPACT_W-1:0] impact;
		logic                armed;
	} tap_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;
	typedef enum {SHAPE_REST, SHAPE_KNOCK, SHAPE_NOISE} shape_t;

	typedef struct packed {
		row_kind_t             kind;
		reg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		accel_sample_t         smp;
		logic                  known;
		tap_result_t           want;
	} dir_row_t;

	typedef struct {
		logic                  en;
		logic [CFG_DATA_W-1:0] thr;
		logic [CFG_DATA_W-1:0] cool;
		logic                  act;
		int                    items;
	} phase_cfg_t;

	localparam int DIR_ROWS = 28;

	logic clk = 1'b0;
	logic arst_n;

	atd_sample_if smp();
	atd_result_if res();
	atd_cfg_if    cfg_bus();

	accel_tap_detector uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res),
		.cfg    (cfg_bus)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies held by the predictor
	logic               en_q     = ENABLE_RST;
	logic [THR_W-1:0]   thr_q    = THRESHOLD_RST;
	logic [COOL_W-1:0]  cool_q   = COOLDOWN_RST;
	logic               action_q = ACTION_RST;

	// detector state held by the predictor
	logic [BASE_W-1:0]  baseline_q = '0;
	logic [TIME_W-1:0]  last_tap_q = '0;
	logic               armed_q    = 1'b0;

	tap_result_t        tap_reports_due[$];
	int                 mismatches  = 0;
	int                 quiet_cycles = 0;
	logic [TIME_W-1:0]  cur_time = 32'd5000;
	logic               hold_results = 1'b0;
	logic               steady_feed  = 1'b0;
	int                 burst_left   = 0;

	// directed stimulus; expected values typed in only where obvious
	dir_row_t dir_rows [DIR_ROWS] = '{
		// power-up: baseline seeds from zero and the detector arms
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd0, 16'sd0, 16'sd0, 32'd1000, 1'b0},
			1'b1, '{1'b0, 1'b0, 16'd0, 1'b1}},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd4096, 16'sd0, 16'sd0, 32'd1010, 1'b0},
			1'b1, '{1'b0, 1'b0, 16'd0, 1'b1}},
		// full-scale knock, then samples inside the cooldown
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd32767, 16'sd32767, 16'sd32767, 32'd1020,
			1'b0}, 1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd4096, 16'sd0, 16'sd0, 32'd1100, 1'b0},
			1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sh8000, 16'sh8000, 16'sh8000, 32'd1200,
			1'b0}, 1'b0, '0},
		// tilt busy disarms and reports nothing
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd4096, 16'sd0, 16'sd0, 32'd1600, 1'b1},
			1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd0, 16'sd4096, 16'sd0, 32'd1700, 1'b0},
			1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd0, 16'sd0, -16'sd4096, 32'd1800, 1'b0},
			1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd0, 16'sd0, 16'sd12288, 32'd1900, 1'b0},
			1'b0, '0},
		// previous-page action, no cooldown
		'{ROW_REG, REG_ACTION,   16'h0, '0, 1'b0, '0},
		'{ROW_REG, REG_COOLDOWN, 16'h0, '0, 1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd4096, 16'sd0, 16'sd0, 32'd2000, 1'b0},
			1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd0, 16'sd0, 16'sd4096, 32'd2010, 1'b0},
			1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd20000, -16'sd20000, 16'sd0, 32'd2020,
			1'b0}, 1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd4096, 16'sd0, 16'sd0, 32'd2030, 1'b1},
			1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
		// detection off: state frozen, armed still clear from the busy beat
		'{ROW_REG, REG_ENABLE, 16'h0, '0, 1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd32767, 16'sh8000, 16'sd123, 32'd2040,
			1'b0}, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
		'{ROW_REG, REG_ENABLE,    16'h1,    '0, 1'b0, '0},
		// threshold written with all data bits set, longest cooldown
		'{ROW_REG, REG_THRESHOLD, 16'hFFFF, '0, 1'b0, '0},
		'{ROW_REG, REG_COOLDOWN,  16'hFFFF, '0, 1'b0, '0},
		// timestamp wrap
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd4096, 16'sd0, 16'sd0, 32'hFFFF_FFF0,
			1'b0}, 1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sh8000, 16'sd0, 16'sd0, 32'h0000_0005,
			1'b0}, 1'b0, '0},
		'{ROW_REG, REG_THRESHOLD, 16'h0, '0, 1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd0, 16'sd4096, 16'sd0, 32'h0002_0000,
			1'b0}, 1'b0, '0},
		'{ROW_REG, REG_COOLDOWN,  16'd500, '0, 1'b0, '0},
		'{ROW_REG, REG_ACTION,    16'h1,   '0, 1'b0, '0},
		'{ROW_REG, REG_THRESHOLD, 16'd50,  '0, 1'b0, '0},
		'{ROW_SAMPLE, REG_ENABLE, 16'h0, '{16'sd0, 16'sd0, 16'sd4096, 32'h0003_0000,
			1'b0}, 1'b0, '0}
	};

	phase_cfg_t phases [N_PHASES] = '{
		'{1'b1, 16'd50,   16'd500,   1'b1, 70},
		'{1'b1, 16'd0,    16'd0,     1'b0, 70},
		'{1'b1, 16'hFFFF, 16'hFFFF,  1'b1, 70},
		'{1'b1, 16'd25,   16'd200,   1'b0, 70},
		'{1'b0, 16'd120,  16'd100,   1'b1, 20},
		'{1'b1, 16'd40,   16'd0,     1'b1, 70},
		'{1'b1, 16'd50,   16'd500,   1'b0, 70},
		'{1'b1, 16'd70,   16'd1000,  1'b1, 70},
		'{1'b1, 16'd800,  16'd65535, 1'b0, 40}
	};

	function automatic logic [AXIS_W-1:0] abs_axis(logic signed [AXIS_W-1:0] v);
		return v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
	endfunction

	// floor square root, one result bit per pass from the top
	function automatic logic [ROOT_W-1:0] floor_root(logic [SUM_W-1:0] n);
		logic [ROOT_W-1:0] r;
		logic [ROOT_W-1:0] t;
		logic [SUM_W-1:0]  sq;
		r = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			t  = r | (ROOT_W'(1) << b);
			sq = SUM_W'(t) * SUM_W'(t);
			if (sq <= n)
				r = t;
		end
		return r;
	endfunction

	// works out the report for one sample and advances the detector state
	function automatic tap_result_t predict_tap(accel_sample_t s);
		tap_result_t       r;
		logic [AXIS_W-1:0] mx, my, mz;
		logic [SUM_W-1:0]  energy;
		longint            mag_fx, base, dev;
		logic [TIME_W-1:0] since;
		r = '0;
		if (!en_q) begin
			r.armed = armed_q;
			return r;
		end
		if (s.busy) begin
			armed_q = 1'b0;
			return r;
		end
		mx = abs_axis(s.ax);
		my = abs_axis(s.ay);
		mz = abs_axis(s.az);
		energy = SUM_W'(mx) * SUM_W'(mx) + SUM_W'(my) * SUM_W'(my) + SUM_W'(mz) * SUM_W'(mz);
		mag_fx = longint'(floor_root(energy)) << FRAC_DEF;

		// baseline: seed while below 0.1 g, else EMA
		base = longint'(baseline_q);
		if (base * SEED_TENTHS < ONE_G_FX)
			base = mag_fx;
		else
			base = (EMA_KEEP * base + mag_fx + EMA_DIV / 2) / EMA_DIV;
		if (base > BASE_CEIL)
			base = BASE_CEIL;
		baseline_q = BASE_W'(base);

		dev = (mag_fx >= base) ? mag_fx - base : base - mag_fx;
		r.impact = ((dev >> FRAC_DEF) > IMPACT_CEIL) ? '1 : IMPACT_W'(dev >> FRAC_DEF);

		// cooldown, re-arm and threshold
		since = s.tms - last_tap_q;
		if (since < TIME_W'(cool_q)) begin
			armed_q = 1'b0;
		end else if (!armed_q) begin
			if (dev * 100 < REARM_CENTI_G * ONE_G_FX)
				armed_q = 1'b1;
		end else if (dev * 100 > longint'(thr_q) * ONE_G_FX) begin
			last_tap_q = s.tms;
			armed_q    = 1'b0;
			r.tap      = 1'b1;
			r.page     = action_q;
		end
		r.armed = armed_q;
		return r;
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int jitter(int a);
		return int'($urandom_range(0, 2 * a)) - a;
	endfunction

	// timestamp: mostly small steps, sometimes a long jump or a fresh value
	function automatic logic [TIME_W-1:0] stamp_now();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			cur_time = cur_time + $urandom_range(60000, 200000);
		else if (r < 5)
			cur_time = $urandom;
		else
			cur_time = cur_time + $urandom_range(1, 30);
		return cur_time;
	endfunction

	function automatic accel_sample_t make_sample(shape_t shape, axis_t up, logic flip);
		accel_sample_t s;
		int            lvl;
		s.ax = AXIS_W'(jitter(250));
		s.ay = AXIS_W'(jitter(250));
		s.az = AXIS_W'(jitter(250));
		lvl  = flip ? -G_COUNTS : G_COUNTS;
		if (shape == SHAPE_KNOCK) begin
			if ($urandom_range(0, 1))
				lvl = lvl + int'($urandom_range(200, 4000)) * ($urandom_range(0, 1) ? 1 : -1);
			else
				lvl = lvl + int'($urandom_range(4000, 28000)) * ($urandom_range(0, 1) ? 1 : -1);
		end
		case (up)
			AXIS_X: s.ax = AXIS_W'(lvl);
			AXIS_Y: s.ay = AXIS_W'(lvl);
			default: s.az = AXIS_W'(lvl);
		endcase
		if (shape == SHAPE_NOISE) begin
			s.ax = AXIS_W'($urandom);
			s.ay = AXIS_W'($urandom);
			s.az = AXIS_W'($urandom);
		end
		s.tms  = stamp_now();
		s.busy = ($urandom_range(0, 99) < 5);
		return s;
	endfunction

	// offers one sample beat and books its expected report once accepted
	task automatic offer_sample(input accel_sample_t s, input logic known,
			input tap_result_t want);
		int          gap;
		tap_result_t due;
		gap = (steady_feed || burst_left > 0) ? 0 : idle_gap();
		if (burst_left > 0)
			burst_left--;
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid     <= 1'b1;
		smp.accel_x   <= s.ax;
		smp.accel_y   <= s.ay;
		smp.accel_z   <= s.az;
		smp.time_ms   <= s.tms;
		smp.tilt_busy <= s.busy;
		@(posedge clk);
		while (smp.ready !== 1'b1)
			@(posedge clk);
		due = predict_tap(s);
		tap_reports_due.push_back(known ? want : due);
	endtask

	task automatic wait_reports_done();
		smp.valid <= 1'b0;
		while (tap_reports_due.size() != 0)
			@(posedge clk);
	endtask

	// leaves valid high; the caller lowers it after the last write
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		@(posedge clk);
		while (cfg_bus.ready !== 1'b1)
			@(posedge clk);
		case (idx)
			REG_ENABLE:    en_q     = val[0];
			REG_THRESHOLD: thr_q    = val[THR_W-1:0];
			REG_COOLDOWN:  cool_q   = val[COOL_W-1:0];
			REG_ACTION:    action_q = val[0];
			default: ;
		endcase
	endtask

	// stimulus
	initial begin : stimulus
		phase_cfg_t pc;
		int         sent;
		logic       squeezed, paused, flip;
		axis_t      up;
		smp.valid     <= 1'b0;
		smp.accel_x   <= '0;
		smp.accel_y   <= '0;
		smp.accel_z   <= '0;
		smp.time_ms   <= '0;
		smp.tilt_busy <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_ENABLE;
		cfg_bus.data  <= '0;
		arst_n        <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_REG) begin
				if (i == 0 || dir_rows[i-1].kind == ROW_SAMPLE)
					wait_reports_done();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
				if (i == DIR_ROWS - 1 || dir_rows[i+1].kind == ROW_SAMPLE)
					cfg_bus.valid <= 1'b0;
			end else begin
				offer_sample(dir_rows[i].smp, dir_rows[i].known, dir_rows[i].want);
			end
		end

		// random phases: rest runs, most followed by a knock, plus some noise
		for (int p = 0; p < N_PHASES; p++) begin
			wait_reports_done();
			pc = phases[p];
			if (p == RANDOM_PHASE) begin
				pc.thr  = $urandom_range(5, 300);
				pc.cool = $urandom_range(0, 2000);
				pc.act  = $urandom_range(0, 1);
			end
			write_reg(REG_ENABLE, CFG_DATA_W'(pc.en));
			write_reg(REG_THRESHOLD, pc.thr);
			write_reg(REG_COOLDOWN, pc.cool);
			write_reg(REG_ACTION, CFG_DATA_W'(pc.act));
			cfg_bus.valid <= 1'b0;
			steady_feed = (p == STEADY_PHASE);
			if (p == WRAP_PHASE)
				cur_time = 32'hFFFF_FE00;
			sent     = 0;
			squeezed = 1'b0;
			paused   = 1'b0;
			while (sent < pc.items) begin
				up   = axis_t'($urandom_range(0, 2));
				flip = $urandom_range(0, 1);
				repeat ($urandom_range(3, 10)) begin
					offer_sample(make_sample(SHAPE_REST, up, flip), 1'b0, '0);
					sent++;
				end
				if ($urandom_range(0, 99) < 80) begin
					offer_sample(make_sample(SHAPE_KNOCK, up, flip), 1'b0, '0);
					sent++;
				end
				if ($urandom_range(0, 99) < 12) begin
					offer_sample(make_sample(SHAPE_NOISE, up, flip), 1'b0, '0);
					sent++;
				end
				// receiver holds off while samples keep coming
				if (p == PRESSURE_PHASE && !squeezed && sent >= 30) begin
					hold_results = 1'b1;
					burst_left   = 8;
					squeezed     = 1'b1;
				end
				// sender pauses until all reports are back
				if (p == RANDOM_PHASE && !paused && sent >= 35) begin
					wait_reports_done();
					paused = 1'b1;
				end
			end
		end
		steady_feed = 1'b0;

		wait_reports_done();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tap_reports_due.size() != 0) begin
			mismatches++;
			$display("%0d reports never arrived", tap_reports_due.size());
		end
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// result side: ready runs, random stalls, one long hold-off on request
	initial begin : result_sink
		int run, gap;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_results) begin
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end
			res.ready <= 1'b1;
			run = ($urandom_range(0, 99) < 15) ? $urandom_range(60, 150) : $urandom_range(1, 20);
			repeat (run) @(posedge clk);
			gap = idle_gap();
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// compare each report beat with the oldest expectation
	always @(posedge clk) begin
		tap_result_t got, want;
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
			got = '{res.tap_detected, res.page_next, res.impact, res.armed};
			if (tap_reports_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected report tap=%0b page=%0b impact=%0d armed=%0b",
						$realtime, got.tap, got.page, got.impact, got.armed);
			end else begin
				want = tap_reports_due.pop_front();
				if (got.tap !== want.tap || got.page !== want.page ||
						got.impact !== want.impact || got.armed !== want.armed) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: want tap=%0b page=%0b impact=%0d armed=%0b, got tap=%0b page=%0b impact=%0d armed=%0b",
							$realtime, want.tap, want.page, want.impact, want.armed,
							got.tap, got.page, got.impact, got.armed);
				end
			end
		end
	end

	// watchdog: cycles with no beat on any channel
	always @(posedge clk) begin
		if ((smp.valid === 1'b1 && smp.ready === 1'b1) ||
				(res.valid === 1'b1 && res.ready === 1'b1) ||
				(cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("tb failed");
			$finish;
		end
	end

endmodule

// File: accel_tap_detector.f
design/atd_pkg.sv
design/atd_ifs.sv
design/atd_cfg.sv
design/atd_ctrl.sv
design/atd_dp.sv
design/accel_tap_detector.sv
design/atd_checker.sv
test/tb.sv
